// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/tsfa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsfa_pkg
// Shared types and constants of the typed serial frame assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package tsfa_pkg;

   // Frame kinds as they appear on the result channel.
   localparam logic [2:0] KIND_DOUBLE = 3'd0;
   localparam logic [2:0] KIND_INT    = 3'd1;
   localparam logic [2:0] KIND_STRING = 3'd2;
   localparam logic [2:0] KIND_CMD    = 3'd3;
   localparam logic [2:0] KIND_RAW    = 3'd4;
   localparam logic [2:0] KIND_NONE   = 3'd7;

   // Operating modes.
   localparam logic [1:0] MODE_IGNORE = 2'd0;
   localparam logic [1:0] MODE_FRAME  = 2'd1;
   localparam logic [1:0] MODE_RAW    = 2'd2;

   // Character constants.
   localparam logic [7:0] CHAR_X     = 8'h58;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // Register file layout.
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_MODE        = 3'd0;
   localparam logic [2:0] REG_DOUBLE_TYPE = 3'd1;
   localparam logic [2:0] REG_INT_TYPE    = 3'd2;
   localparam logic [2:0] REG_STRING_TYPE = 3'd3;
   localparam logic [2:0] REG_CMD_MARKER  = 3'd4;
   localparam logic [2:0] REG_ERROR_FILL  = 3'd5;
   localparam logic [2:0] REG_CHECK_ON    = 3'd6;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] double_type_byte;
      logic [7:0] int_type_byte;
      logic [7:0] string_type_byte;
      logic [7:0] command_marker_byte;
      logic [7:0] error_fill_byte;
      logic       format_check_on;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic process;    // accepted byte in frame mode
      logic raw_load;   // accepted byte in raw mode
      logic append_cr;  // write the trailing carriage return and close the frame
      logic rd_issue;   // read the store at the emit index
      logic advance;    // step the emit index
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic nl_hit;      // the byte being processed ends a data frame
      logic cmd_hit;     // the byte being processed ends a command frame
      logic cmd_len_nz;  // the length of the closing command frame does not wrap to zero
      logic last;        // the byte being shown is the last of its frame
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/tsfa_csr.sv =====
// ----------------------------------------------------------------------------
// tsfa_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfa_csr import tsfa_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MODE:        cfg_in.mode                = pwdata[1:0];
            REG_DOUBLE_TYPE: cfg_in.double_type_byte    = pwdata[7:0];
            REG_INT_TYPE:    cfg_in.int_type_byte       = pwdata[7:0];
            REG_STRING_TYPE: cfg_in.string_type_byte    = pwdata[7:0];
            REG_CMD_MARKER:  cfg_in.command_marker_byte = pwdata[7:0];
            REG_ERROR_FILL:  cfg_in.error_fill_byte     = pwdata[7:0];
            REG_CHECK_ON:    cfg_in.format_check_on     = pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode                <= MODE_IGNORE;
         cfg_ff.double_type_byte    <= 8'd100;
         cfg_ff.int_type_byte       <= 8'd105;
         cfg_ff.string_type_byte    <= 8'd115;
         cfg_ff.command_marker_byte <= 8'd35;
         cfg_ff.error_fill_byte     <= 8'd63;
         cfg_ff.format_check_on     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MODE:        prdata = {30'd0, cfg_ff.mode};
         REG_DOUBLE_TYPE: prdata = {24'd0, cfg_ff.double_type_byte};
         REG_INT_TYPE:    prdata = {24'd0, cfg_ff.int_type_byte};
         REG_STRING_TYPE: prdata = {24'd0, cfg_ff.string_type_byte};
         REG_CMD_MARKER:  prdata = {24'd0, cfg_ff.command_marker_byte};
         REG_ERROR_FILL:  prdata = {24'd0, cfg_ff.error_fill_byte};
         REG_CHECK_ON:    prdata = {31'd0, cfg_ff.format_check_on};
         default:         prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/tsfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsfa_ctrl
// Sequencer for byte intake, carriage-return append and frame drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfa_ctrl import tsfa_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [1:0]    mode,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPEND,
      ST_READ,
      ST_SEND
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      stall_ff;
   logic      valid_ff;
   logic      accept;

   assign accept = req_valid && !stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode)
                  MODE_RAW: begin
                     cmd.raw_load = 1'b1;
                     state_in     = ST_SEND;
                  end
                  MODE_FRAME: begin
                     cmd.process = 1'b1;
                     if (status.nl_hit) begin
                        state_in = ST_APPEND;
                     end else if (status.cmd_hit && status.cmd_len_nz) begin
                        state_in = ST_READ;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_APPEND: begin
            cmd.append_cr = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
         valid_ff <= (state_in == ST_SEND);
      end
   end

   assign req_stall = stall_ff;
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// ===== design/tsfa_datapath.sv =====
// ----------------------------------------------------------------------------
// tsfa_datapath
// Frame store, fill and marker counters, type claim and output formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfa_datapath import tsfa_pkg::*; #(
   parameter int FRAME_DEPTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire ctrl_cmd_type cmd,
   input  wire logic [7:0]   rx_byte,
   output dp_status_type     status,
   output logic [7:0]        out_byte,
   output logic [2:0]        frame_kind,
   output logic              last_of_frame
);

   localparam int AW = $clog2(FRAME_DEPTH);
   localparam int CW = $clog2(FRAME_DEPTH + 1);

   logic [7:0]    mem [FRAME_DEPTH];

   logic [AW-1:0] fill_ff;
   logic [AW-1:0] fill_in;
   logic [2:0]    ftype_ff;
   logic [2:0]    ftype_in;
   logic [1:0]    mark_ff;
   logic [1:0]    mark_in;
   logic [2:0]    kind_ff;
   logic [2:0]    kind_in;
   logic [CW-1:0] len_ff;
   logic [CW-1:0] len_in;
   logic [AW-1:0] idx_ff;
   logic [AW-1:0] idx_in;
   logic [7:0]    rd_data_ff;
   logic [7:0]    lead_ff;

   logic [2:0]    claim;
   logic          active;
   logic          is_cmd;
   logic [1:0]    mark_next;
   logic [AW-1:0] fill_wrap;
   logic          wr_en;
   logic [7:0]    wr_data;

   logic          xform_on;
   logic          numeric;
   logic [7:0]    extra;
   logic [7:0]    lead_ref;
   logic [7:0]    chk1;
   logic [7:0]    chk2;

   function automatic logic is_line_end(input logic [7:0] c);
      return (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

   // Type claim: the first matching type byte wins while no frame is open.
   always_comb begin
      if (ftype_ff != KIND_NONE) begin
         claim = ftype_ff;
      end else if (rx_byte == cfg.double_type_byte) begin
         claim = KIND_DOUBLE;
      end else if (rx_byte == cfg.int_type_byte) begin
         claim = KIND_INT;
      end else if (rx_byte == cfg.string_type_byte) begin
         claim = KIND_STRING;
      end else if (rx_byte == cfg.command_marker_byte) begin
         claim = KIND_CMD;
      end else begin
         claim = KIND_NONE;
      end
   end

   assign active    = (claim != KIND_NONE) && (rx_byte != CHAR_NUL);
   assign is_cmd    = (claim == KIND_CMD);
   assign mark_next = mark_ff + {1'b0, rx_byte == cfg.command_marker_byte};
   assign fill_wrap = (fill_ff == AW'(FRAME_DEPTH - 1)) ? '0 : AW'(fill_ff + 1'b1);

   assign status.nl_hit     = active && !is_cmd && (rx_byte == CHAR_LF);
   assign status.cmd_hit    = active && is_cmd && (mark_next == 2'd2);
   assign status.cmd_len_nz = (fill_wrap != '0);
   assign status.last       = (kind_ff == KIND_RAW) ||
                              ((CW'(idx_ff) + 1'b1) == len_ff);

   assign wr_en   = (cmd.process && active) || cmd.append_cr;
   assign wr_data = cmd.append_cr ? CHAR_CR : rx_byte;

   always_comb begin
      fill_in  = fill_ff;
      ftype_in = ftype_ff;
      mark_in  = mark_ff;
      kind_in  = kind_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      if (cmd.process) begin
         ftype_in = claim;
         if (active) begin
            fill_in = fill_wrap;
            if (is_cmd) begin
               mark_in = mark_next;
            end
            if (status.cmd_hit) begin
               fill_in  = '0;
               ftype_in = KIND_NONE;
               mark_in  = 2'd0;
               len_in   = CW'(fill_wrap);
               kind_in  = KIND_CMD;
               idx_in   = '0;
            end
         end
      end
      if (cmd.append_cr) begin
         // A wrap to zero here means the store holds a full frame.
         fill_in  = '0;
         ftype_in = KIND_NONE;
         len_in   = (fill_wrap == '0) ? CW'(FRAME_DEPTH) : CW'(fill_wrap);
         kind_in  = ftype_ff;
         idx_in   = '0;
      end
      if (cmd.raw_load) begin
         kind_in = KIND_RAW;
      end
      if (cmd.advance) begin
         idx_in = AW'(idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         ftype_ff <= KIND_NONE;
         mark_ff  <= 2'd0;
         kind_ff  <= KIND_NONE;
         len_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         fill_ff  <= fill_in;
         ftype_ff <= ftype_in;
         mark_ff  <= mark_in;
         kind_ff  <= kind_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
      end
   end

   // The store, its registered read port, and a copy of the first entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff] <= wr_data;
         if (fill_ff == '0) begin
            lead_ff <= wr_data;
         end
      end
      if (cmd.raw_load) begin
         rd_data_ff <= rx_byte;
      end else if (cmd.rd_issue) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   // Format check on the way out; the first byte of a frame passes unchanged.
   assign xform_on = cfg.format_check_on && (idx_ff != '0) &&
                     ((kind_ff == KIND_DOUBLE) || (kind_ff == KIND_INT) ||
                      (kind_ff == KIND_STRING));
   assign numeric  = (kind_ff == KIND_DOUBLE) || (kind_ff == KIND_INT);
   assign extra    = (kind_ff == KIND_DOUBLE) ? CHAR_DOT : CHAR_MINUS;

   always_comb begin
      case (kind_ff)
         KIND_DOUBLE: lead_ref = cfg.double_type_byte;
         KIND_INT:    lead_ref = cfg.int_type_byte;
         default:     lead_ref = cfg.string_type_byte;
      endcase
   end

   always_comb begin
      chk1 = rd_data_ff;
      if (numeric && !((rd_data_ff >= CHAR_ZERO) && (rd_data_ff <= CHAR_NINE)) &&
          (rd_data_ff != extra) && !is_line_end(rd_data_ff)) begin
         chk1 = cfg.error_fill_byte;
      end
      chk2 = chk1;
      if ((lead_ff != lead_ref) && !is_line_end(chk1)) begin
         chk2 = CHAR_X;
      end
   end

   assign out_byte      = xform_on ? chk2 : rd_data_ff;
   assign frame_kind    = kind_ff;
   assign last_of_frame = status.last;

endmodule

`default_nettype wire

// ===== design/typed_serial_frame_assembler_top.sv =====
// ----------------------------------------------------------------------------
// typed_serial_frame_assembler_top
// Assembles typed frames from received serial bytes and emits them bytewise.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   req_      in         valid / stall      rx_byte
//   rsp_      out        valid / stall      out_byte, frame_kind, last_of_frame
//   csr_      in         psel / penable     paddr, pwdata, prdata (APB-style)
//
// A byte that is ignored or only stored leaves req_stall low, and the next
// transaction may be accepted in the following cycle.
// A byte that closes a frame holds req_stall high while the frame drains
// (and first while the carriage return of a data frame is written) and
// during any rsp_stall; each output byte is first read from the single-port
// frame store into its registered read data and then shown on the result
// channel. A raw byte is accepted and then shown before the next is taken.
// Reset is synchronous and active high; it restores the register defaults and
// clears the frame state. The frame store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module typed_serial_frame_assembler_top import tsfa_pkg::*; #(
   parameter int FRAME_DEPTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Received byte channel.
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_rx_byte,
   // Emitted frame channel.
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic [2:0]                 rsp_frame_kind,
   output logic                       rsp_last_of_frame,
   // Configuration port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The port never inserts wait states.
   assign csr_pready = 1'b1;

   tsfa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // The controller decides when a transaction is accepted and sequences the
   // append and drain of a finished frame.
   tsfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .mode      (cfg.mode),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath owns the frame store and all frame state, and formats each
   // byte as it leaves the store.
   tsfa_datapath #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .rx_byte       (req_rx_byte),
      .status        (status),
      .out_byte      (rsp_out_byte),
      .frame_kind    (rsp_frame_kind),
      .last_of_frame (rsp_last_of_frame)
   );

   // While input is open, no result may be pending.
   `ASSERT_IMPLY(a_idle_no_result, clock, reset, !req_stall, !rsp_valid)
   // Once the last byte of a frame is taken, the block returns to intake.
   `ASSERT_NEXT(a_last_ends_drain, clock, reset,
                rsp_valid && rsp_last_of_frame && !rsp_stall, !rsp_valid && !req_stall)
   // Every raw byte is a frame of its own.
   `ASSERT_IMPLY(a_raw_is_last, clock, reset,
                 rsp_valid && (rsp_frame_kind == KIND_RAW), rsp_last_of_frame)

endmodule

`default_nettype wire
